>>> design/sliding_window_ratio_checker_assert.svh
// Assertion macros for the sliding-window ratio checker.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_WINDOW_RATIO_CHECKER_ASSERT_SVH
`define SLIDING_WINDOW_RATIO_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SWRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SWRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/swrc_pkg.sv
// Package for the sliding-window ratio checker: payload structs, command and
// register codes, field widths. No dependencies.
`timescale 1ns / 1ps

package swrc_pkg;

  localparam int OPT_W       = 8;   // option vector width
  localparam int FIELD_W     = 5;   // per-option field in the config words
  localparam int CFG_W       = 40;  // config word width
  localparam int CFG_IDX_W   = 1;
  localparam int LEN_W       = 16;
  localparam int CMD_W       = 2;
  localparam int N_OPTIONS   = 8;
  localparam int WINDOW_MAX  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROBE  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZES = 1'b0,
    REG_MAX_COUNTS   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [OPT_W-1:0] option_bits;
  } item_t;

  typedef struct packed {
    logic             feasible;
    logic [OPT_W-1:0] violation_mask;
    logic [LEN_W-1:0] stored_length;
  } result_t;

endpackage

>>> design/swrc_lane.sv
// One option lane: counts the option in the window ending at the new item
// and compares against the limit. Depends on swrc_pkg.
`timescale 1ns / 1ps

module swrc_lane
  import swrc_pkg::*;
#(
  parameter int HIST_DEPTH = WINDOW_MAX - 1
) (
  input  logic [HIST_DEPTH-1:0] hist_bits,  // index 0 is newest
  input  logic                  carried,
  input  logic [FIELD_W-1:0]    window,
  input  logic [FIELD_W-1:0]    limit,
  output logic                  violation
);

  localparam int CNT_W = $clog2(HIST_DEPTH + 2);
  localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  logic [HIST_DEPTH-1:0] sel;
  logic [CNT_W-1:0]      count;

  always_comb begin
    for (int k = 0; k < HIST_DEPTH; k++) begin
      // entry k lies in the window when k+1 < W
      sel[k] = hist_bits[k] && (FIELD_W'(k + 1) < window);
    end
    count = CNT_W'($countones(sel)) + CNT_W'(1);
  end

  assign violation = carried && (window != '0) &&
                     (CMP_W'(count) > CMP_W'(limit));

endmodule

>>> design/swrc_merge.sv
// Merge stage: combines lane violation bits into a result and holds it in
// an output register backed by a skid register. Depends on swrc_pkg.
`timescale 1ns / 1ps

module swrc_merge
  import swrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [OPT_W-1:0] vmask,
  input  logic [LEN_W-1:0] length,
  output logic             push_ready,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result
);

  result_t fresh;
  result_t out_q;
  result_t skid_q;
  logic    out_valid;
  logic    skid_valid;

  always_comb begin
    fresh.feasible       = (vmask == '0);
    fresh.violation_mask = vmask;
    fresh.stored_length  = length;
  end

  assign push_ready   = !skid_valid;
  assign result_valid = out_valid;
  assign result       = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (push) begin
        out_valid <= 1'b1;
      end
    end else if (result_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result_ready) begin
      if (out_valid && skid_valid) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= fresh;
      end
    end else if (push) begin
      skid_q <= fresh;
    end
  end

endmodule

>>> design/sliding_window_ratio_checker.sv
// A result is valid the cycle after its transfer unless the output is stalled.
// Throughput: one item per cycle while the skid register is empty; every lane
// reads the history shift register in the same cycle; the skid holds one result.
// Reset (synchronous): history cleared to no options, length zero, both
// config words zero, output stage empty. No clearing pass.
// Top level; depends on swrc_pkg, swrc_lane, swrc_merge and the assert header.
`timescale 1ns / 1ps
`include "sliding_window_ratio_checker_assert.svh"

module sliding_window_ratio_checker
  import swrc_pkg::*;
#(
  parameter int NUM_OPTIONS = N_OPTIONS,
  parameter int MAX_WINDOW  = WINDOW_MAX
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int HIST_DEPTH = MAX_WINDOW - 1;

  logic [CFG_W-1:0] window_sizes;
  logic [CFG_W-1:0] max_counts;
  logic [OPT_W-1:0] hist [HIST_DEPTH];
  logic [LEN_W-1:0] appended_total;
  logic [LEN_W-1:0] appended_total_next;
  logic [OPT_W-1:0] lane_viol;
  logic [OPT_W-1:0] vmask;
  logic             accept;
  logic             is_clear;
  logic             is_append;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;
  assign is_clear  = (item.command == CMD_CLEAR);
  assign is_append = (item.command == CMD_APPEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sizes <= '0;
      max_counts   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WINDOW_SIZES) begin
        window_sizes <= cfg_data;
      end
      if (cfg_index == REG_MAX_COUNTS) begin
        max_counts <= cfg_data;
      end
    end
  end

  // one lane per option, each looking at its column of the history
  genvar j;
  generate
    for (j = 0; j < OPT_W; j++) begin : g_lane
      if (j < NUM_OPTIONS) begin : g_on
        logic [HIST_DEPTH-1:0] col;
        always_comb begin
          for (int k = 0; k < HIST_DEPTH; k++) begin
            col[k] = hist[k][j];
          end
        end
        swrc_lane #(
          .HIST_DEPTH(HIST_DEPTH)
        ) u_lane (
          .hist_bits(col),
          .carried  (item.option_bits[j]),
          .window   (window_sizes[FIELD_W*j +: FIELD_W]),
          .limit    (max_counts[FIELD_W*j +: FIELD_W]),
          .violation(lane_viol[j])
        );
      end else begin : g_off
        assign lane_viol[j] = 1'b0;
      end
    end
  endgenerate

  assign vmask = is_clear ? '0 : lane_viol;

  always_comb begin
    appended_total_next = appended_total;
    if (is_clear) begin
      appended_total_next = '0;
    end else if (is_append && (appended_total != '1)) begin
      appended_total_next = appended_total + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      appended_total <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] <= '0;
      end
    end else if (accept) begin
      appended_total <= appended_total_next;
      if (is_clear) begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist[k] <= '0;
        end
      end else if (is_append) begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
          hist[k] <= hist[k-1];
        end
        hist[0] <= item.option_bits;
      end
    end
  end

  swrc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .vmask       (vmask),
    .length      (appended_total_next),
    .push_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  `SWRC_ASSERT_NEXT(a_clear_len, clk, rst, accept && is_clear, appended_total == '0, "clear did not zero length")
  `SWRC_ASSERT_NEXT(a_append_len, clk, rst, accept && is_append && (appended_total != '1), appended_total == LEN_W'($past(appended_total) + LEN_W'(1)), "append did not count")
  `SWRC_ASSERT_NOW(a_stall_full, clk, rst, !item_ready, result_valid, "input stalled with output empty")
  `SWRC_ASSERT_NEXT(a_clear_result, clk, rst, accept && is_clear && !result_valid, result.feasible && (result.violation_mask == '0) && (result.stored_length == '0), "clear result wrong")

endmodule

>>> bench/sliding_window_ratio_checker_tb.sv
// Self-checking bench for sliding_window_ratio_checker: directed table and
// randomised phases, scored against a local predictor or, in typed rows, the table.
// Depends on swrc_pkg and the block under test only.
`timescale 1ns / 1ps

module sliding_window_ratio_checker_tb;
  import swrc_pkg::*;

  localparam int HIST_LEN  = WINDOW_MAX - 1;
  localparam int N_ROWS    = 21;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 112;
  localparam int HOLD_CYC  = 80;

  typedef struct packed {
    bit                   is_cfg;
    cmd_e                 cmd;
    logic [OPT_W-1:0]     opts;
    cfg_reg_e             reg_idx;
    logic [CFG_W-1:0]     value;
    bit                   typed;
    result_t              want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_ready;
  item_t                item;
  logic                 result_valid;
  logic                 result_ready;
  result_t              result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  logic [OPT_W-1:0] recent_opts [HIST_LEN];
  logic [LEN_W-1:0] append_count;
  logic [CFG_W-1:0] win_cfg;
  logic [CFG_W-1:0] limit_cfg;

  result_t     pending_results [$];
  int unsigned mismatches;
  int unsigned burst_left;
  bit          rx_free;
  bit          hold_req;
  row_t        directed_plan [N_ROWS];

  sliding_window_ratio_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // options over the limit in the window ending at the new item
  function automatic logic [OPT_W-1:0] over_limit(logic [OPT_W-1:0] opts);
    logic [OPT_W-1:0] mask;
    int               w;
    int               q;
    int               hits;
    mask = '0;
    for (int j = 0; j < N_OPTIONS; j++) begin
      w = int'(win_cfg[FIELD_W*j +: FIELD_W]);
      q = int'(limit_cfg[FIELD_W*j +: FIELD_W]);
      if (w == 0 || !opts[j]) continue;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      hits = 1;
      for (int k = 0; k < w - 1; k++)
        if (recent_opts[k][j]) hits++;
      if (hits > q) mask[j] = 1'b1;
    end
    return mask;
  endfunction

  function automatic result_t apply_command(item_t it);
    result_t r;
    r.violation_mask = '0;
    if (it.command == CMD_CLEAR) begin
      for (int k = 0; k < HIST_LEN; k++) recent_opts[k] = '0;
      append_count = '0;
    end else begin
      r.violation_mask = over_limit(it.option_bits);
      if (it.command == CMD_APPEND) begin
        for (int k = HIST_LEN - 1; k > 0; k--) recent_opts[k] = recent_opts[k-1];
        recent_opts[0] = it.option_bits;
        if (append_count != {LEN_W{1'b1}}) append_count++;
      end
    end
    r.feasible      = (r.violation_mask == '0);
    r.stored_length = append_count;
    return r;
  endfunction

  // one item transfer; bursts of back-to-back items separated by random gaps
  task automatic push_item(item_t it, bit typed, result_t want);
    int unsigned idle;
    result_t     pred;
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      idle       = $urandom_range(0, 8);
    end
    burst_left--;
    @(negedge clk);
    if (idle > 0) begin
      item_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pred = apply_command(it);
    pending_results.insert(pending_results.size(), typed ? want : pred);
  endtask

  // stop offering items and wait for the block to drain
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WINDOW_SIZES) win_cfg = data;
    else limit_cfg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report(string what, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %0h", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result.feasible !== want.feasible)
          report("feasible", LEN_W'(want.feasible), LEN_W'(result.feasible));
        if (result.violation_mask !== want.violation_mask)
          report("violation_mask", LEN_W'(want.violation_mask),
                 LEN_W'(result.violation_mask));
        if (result.stored_length !== want.stored_length)
          report("stored_length", want.stored_length, result.stored_length);
      end
    end
  end

  // receiver: switches between random stall modes, one long hold-off on request
  initial begin : rx_side
    int unsigned mode;
    int unsigned left;
    mode = 0;
    left = 0;
    result_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYC; c++) @(negedge clk);
        result_ready <= 1'b1;
      end else if (rx_free) begin
        result_ready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 48);
        end
        left--;
        case (mode)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    item_t            it;
    result_t          none;
    logic [CFG_W-1:0] wcfg;
    logic [CFG_W-1:0] qcfg;
    int unsigned      w;
    int unsigned      q;
    int unsigned      roll;

    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_WINDOW_SIZES;
    cfg_data   <= '0;
    none        = '0;
    mismatches  = 0;
    burst_left  = 0;
    rx_free     = 1'b0;
    hold_req    = 1'b0;
    win_cfg     = '0;
    limit_cfg   = '0;
    append_count = '0;
    for (int k = 0; k < HIST_LEN; k++) recent_opts[k] = '0;

    directed_plan = '{
      '{1'b0, CMD_PROBE,  8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd0}},
      '{1'b0, CMD_APPEND, 8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd1}},
      '{1'b0, CMD_APPEND, 8'h00, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd2}},
      '{1'b0, CMD_CLEAR,  8'hA5, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd0}},
      // windows: 1, 2, 3, 16, 31 (clamped), off, 4, 5
      '{1'b1, CMD_PROBE,  8'h00, REG_WINDOW_SIZES,
        {5'd5, 5'd4, 5'd0, 5'd31, 5'd16, 5'd3, 5'd2, 5'd1}, 1'b0, '0},
      // limits: zero on option 0, wide open on option 7
      '{1'b1, CMD_PROBE,  8'h00, REG_MAX_COUNTS,
        {5'd31, 5'd2, 5'd1, 5'd3, 5'd2, 5'd1, 5'd1, 5'd0}, 1'b0, '0},
      '{1'b0, CMD_PROBE,  8'h00, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd0}},
      '{1'b0, CMD_PROBE,  8'h01, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b0, 8'h01, 16'd0}},
      '{1'b0, CMD_APPEND, 8'hFE, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'hFE, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_PROBE,  8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_RSVD,   8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'h10, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'h00, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_PROBE,  8'h10, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_RSVD,   8'h00, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'h80, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_CLEAR,  8'h00, REG_WINDOW_SIZES, 40'd0, 1'b1, '{1'b1, 8'h00, 16'd0}},
      '{1'b0, CMD_PROBE,  8'hFF, REG_WINDOW_SIZES, 40'd0, 1'b0, '0},
      '{1'b0, CMD_APPEND, 8'h08, REG_WINDOW_SIZES, 40'd0, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
      end else begin
        it.command     = directed_plan[i].cmd;
        it.option_bits = directed_plan[i].opts;
        push_item(it, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      for (int j = 0; j < N_OPTIONS; j++) begin
        case (p)
          0: begin w = 31; q = 0;  end
          1: begin w = 16; q = 31; end
          2: begin w = 1;  q = $urandom_range(0, 1); end
          default: begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                            : $urandom_range(1, 6);
            q = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                            : $urandom_range(0, 4);
          end
        endcase
        wcfg[FIELD_W*j +: FIELD_W] = FIELD_W'(w);
        qcfg[FIELD_W*j +: FIELD_W] = FIELD_W'(q);
      end
      write_reg(REG_WINDOW_SIZES, wcfg);
      write_reg(REG_MAX_COUNTS, qcfg);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 4 && n == 40) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 57)      it.command = CMD_APPEND;
        else if (roll < 88) it.command = CMD_PROBE;
        else if (roll < 91) it.command = CMD_CLEAR;
        else                it.command = CMD_RSVD;
        it.option_bits = OPT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) it.option_bits &= OPT_W'($urandom_range(0, 255));
        push_item(it, 1'b0, none);
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    rx_free     = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/swrc_pkg.sv
design/swrc_lane.sv
design/swrc_merge.sv
design/sliding_window_ratio_checker.sv
bench/sliding_window_ratio_checker_tb.sv
